// ===== hdl/ibt_pkg.sv =====
`timescale 1ns / 1ps
// ibt_pkg: shared types for the interval booking table.
// Used by ibt_scan_ctrl and interval_booking_table; no dependencies.
package ibt_pkg;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } ibt_status_e;

  typedef struct packed {
    logic        booked;
    ibt_status_e status;
  } ibt_result_t;

endpackage

// ===== hdl/ibt_entry_ram.sv =====
`timescale 1ns / 1ps
// ibt_entry_ram: one-write, one-read synchronous RAM, registered read data.
// Holds {start, end} pairs of booked intervals; no dependencies.
module ibt_entry_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 64
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/ibt_scan_ctrl.sv =====
`timescale 1ns / 1ps
// ibt_scan_ctrl: request sequencer; scans the filled entries for overlap,
// then books into the next free slot if no overlap and not full. Depends on ibt_pkg.
module ibt_scan_ctrl #(
  parameter int CAPACITY = 64,
  parameter int TW       = 32,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request side
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  logic [TW-1:0]       start_i,
  input  logic [TW-1:0]       end_i,
  // result side
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output ibt_pkg::ibt_result_t res_o,
  // entry RAM
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  logic [2*TW-1:0]     rd_data_i,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output logic [2*TW-1:0]     wr_data_o
);
  import ibt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_e      state_q, state_d;
  logic [TW-1:0] start_q, start_d, end_q, end_d;
  logic [CW-1:0] count_q, count_d;   // entries 0..count-1 are in use
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic        cmp_vld_q, cmp_vld_d;
  logic        hit_q, hit_d;
  logic        inv_q, inv_d;

  logic [TW-1:0] ent_start, ent_end;
  logic        issue;
  ibt_status_e status;
  logic        finish_go;

  assign ent_start = rd_data_i[2*TW-1:TW];
  assign ent_end   = rd_data_i[TW-1:0];

  assign issue     = (state_q == S_SCAN) && (rd_idx_q < count_q);
  assign rd_en_o   = issue;
  assign rd_addr_o = rd_idx_q[AW-1:0];

  always_comb begin
    if (inv_q) begin
      status = ST_INVALID;
    end else if (hit_q) begin
      status = ST_OVERLAP;
    end else if (count_q == CapCount) begin
      status = ST_FULL;
    end else begin
      status = ST_BOOKED;
    end
  end

  assign finish_go    = (state_q == S_FINISH) && !res_stall_i;
  assign res_valid_o  = (state_q == S_FINISH);
  assign res_o.booked = (status == ST_BOOKED);
  assign res_o.status = status;

  assign wr_en_o   = finish_go && (status == ST_BOOKED);
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = {start_q, end_q};

  assign req_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    start_d   = start_q;
    end_d     = end_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = cmp_vld_q;
    hit_d     = hit_q;
    inv_d     = inv_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          start_d   = start_i;
          end_d     = end_i;
          inv_d     = (start_i >= end_i);
          hit_d     = 1'b0;
          rd_idx_d  = '0;
          cmp_vld_d = 1'b0;
          state_d   = (start_i >= end_i) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        // one read per cycle; data compared in the next cycle
        cmp_vld_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (cmp_vld_q && (ent_start < end_q) && (ent_end > start_q)) begin
          hit_d = 1'b1;
        end
        if (!issue) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!res_stall_i) begin
          if (status == ST_BOOKED) begin
            count_d = count_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      inv_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      inv_q     <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule

// ===== hdl/interval_booking_table.sv =====
`timescale 1ns / 1ps
// interval_booking_table: books non-overlapping half-open intervals [start, end).
// Each request scans the N entries booked so far, one RAM read per cycle; an empty or
// reversed interval skips the scan. One request in flight: the next transfer is taken
// once the sequencer has handed the previous result to the output register.
// Reset (async, active low) empties the table by clearing the fill count; RAM is not cleared.
// Depends on ibt_pkg, ibt_entry_ram, ibt_scan_ctrl.
module interval_booking_table #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          start_time_i,
  input  logic [31:0]          end_time_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 booked_o,
  output logic [1:0]           status_o
);
  import ibt_pkg::*;

  // Times are taken modulo 2^TIME_BITS; ports carry 32 bits, so at most 32 are kept.
  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  // Slot index and fill count widths; the count must also hold CAPACITY itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [2*TW-1:0] rd_data, wr_data;

  logic        res_valid, res_stall;
  ibt_result_t res;

  // Output register: a finished result waits here so the sequencer can
  // take the next request while the downstream side stalls.
  logic        out_valid_q, out_valid_d;
  ibt_result_t out_q;
  logic        load;

  // Entry store: {start, end} per slot, filled in slot order.
  ibt_entry_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (2 * TW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Sequencer: scans filled slots, checks overlap, books or rejects.
  ibt_scan_ctrl #(
    .CAPACITY (CAPACITY),
    .TW       (TW),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .start_i     (start_time_i[TW-1:0]),
    .end_i       (end_time_i[TW-1:0]),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Sequencer result moves in when the register is empty or being drained.
  assign res_stall = out_valid_q && out_stall_i;
  assign load      = res_valid && !res_stall;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign booked_o    = out_q.booked;
  assign status_o    = out_q.status;

endmodule

// ===== tb/tb_interval_booking_table.sv =====
`timescale 1ns / 1ps
// tb_interval_booking_table: self-checking bench for interval_booking_table.
// Drives booking requests, models the table alongside the block and checks each result.
// Depends on ibt_pkg and interval_booking_table.
module tb_interval_booking_table;
  import ibt_pkg::*;

  localparam int CAPACITY  = 64;
  localparam int TIME_BITS = 32;
  localparam int N_RANDOM  = 1880;
  // no idling on either side over the last stretch of requests
  localparam int QUIET_N   = 200;
  // long receiver hold-off starts once this many requests have gone in
  localparam int HOLD_AT   = 500;
  localparam int HOLD_LEN  = 600;

  typedef struct {
    logic [31:0] s;
    logic [31:0] e;
  } booking_req_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [31:0] start_time_i = '0;
  logic [31:0] end_time_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        booked_o;
  logic [1:0]  status_o;

  interval_booking_table #(
    .CAPACITY (CAPACITY),
    .TIME_BITS(TIME_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_time_i(start_time_i),
    .end_time_i  (end_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .booked_o    (booked_o),
    .status_o    (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table shadow. Slots are only read while marked used, so the unwritten
  // contents never matter.
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] slot_start [CAPACITY];
  logic [TIME_BITS-1:0] slot_end   [CAPACITY];
  logic                 slot_used  [CAPACITY];

  booking_req_t pending_reqs[$];
  ibt_result_t  booking_results[$];
  logic [31:0]  hist_start[$];
  logic [31:0]  hist_end[$];
  int           n_errors = 0;
  int           n_sent   = 0;
  int           n_total  = 0;

  initial begin
    for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
  end

  // Checks run invalid, then overlap, then full; a free slot is the lowest unused one.
  function automatic ibt_result_t book_interval(input logic [31:0] s_in, input logic [31:0] e_in);
    logic [TIME_BITS-1:0] s;
    logic [TIME_BITS-1:0] e;
    int                   free_slot;
    logic                 hit;
    ibt_result_t          res;
    s         = s_in[TIME_BITS-1:0];
    e         = e_in[TIME_BITS-1:0];
    free_slot = -1;
    hit       = 1'b0;
    if (s >= e) begin
      res.status = ST_INVALID;
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i]) begin
          // half-open: touching ends do not count
          if (slot_start[i] < e && slot_end[i] > s) hit = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit) begin
        res.status = ST_OVERLAP;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        slot_start[free_slot] = s;
        slot_end[free_slot]   = e;
        slot_used[free_slot]  = 1'b1;
        res.status            = ST_BOOKED;
      end
    end
    res.booked = (res.status == ST_BOOKED);
    return res;
  endfunction

  task automatic add_req(input logic [31:0] s, input logic [31:0] e);
    booking_req_t r;
    r.s = s;
    r.e = e;
    pending_reqs.push_back(r);
    hist_start.push_back(s);
    hist_end.push_back(e);
    n_total++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: valid only changes when the current transfer completes or
  // nothing is offered, so it never reacts to this cycle's stall.
  // ---------------------------------------------------------------------------
  int   tx_gap      = 0;
  int   tx_idle_pct = 20;
  logic tx_quiet;
  assign tx_quiet = (n_sent >= n_total - QUIET_N);

  always @(posedge clk_i or negedge rst_ni) begin
    booking_req_t req;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      start_time_i <= '0;
      end_time_i   <= '0;
      tx_gap       <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        // one request in flight, results in order: predict at the input transfer
        booking_results.push_back(book_interval(start_time_i, end_time_i));
        n_sent <= n_sent + 1;
        // now and then switch between busy, light and no idling
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0:       tx_idle_pct <= 0;
            1:       tx_idle_pct <= 15;
            default: tx_idle_pct <= 50;
          endcase
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!tx_quiet && $urandom_range(0, 99) < tx_idle_pct) begin
          // start an idle burst, this cycle included; tx_gap holds the rest of it
          tx_gap     <= $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req          = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          start_time_i <= req.s;
          end_time_i   <= req.e;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here: the block takes one request, then
  // has to stall its input while the driver keeps offering the next one.
  // ---------------------------------------------------------------------------
  int   hold_cnt   = 0;
  logic hold_armed = 1'b1;
  logic hold_q;
  assign hold_q = (hold_cnt != 0);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt   <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && n_sent == HOLD_AT) begin
      hold_cnt   <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver stall: random bursts plus the hold-off above.
  int rx_gap      = 0;
  int rx_idle_pct = 15;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap      <= 0;
    end else begin
      if ($urandom_range(0, 255) == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_idle_pct <= 0;
          1:       rx_idle_pct <= 5;
          default: rx_idle_pct <= 30;
        endcase
      end
      if (rx_gap != 0) begin
        rx_gap      <= rx_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!tx_quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap      <= $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= hold_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every result transfer is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  ibt_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (booking_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = booking_results.pop_front();
        if (booked_o !== want.booked)
          report_mismatch($sformatf("booked %b, want %b", booked_o, want.booked));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          r;
    int          k;
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] len;
    logic [7:0]  bucket;

    // directed: empty/reversed, field extremes, touching and overlapping shapes
    add_req(32'h0000_0000, 32'h0000_0000);  // empty at zero
    add_req(32'hFFFF_FFFF, 32'h0000_0000);  // reversed, extremes
    add_req(32'd5, 32'd5);                  // empty
    add_req(32'd0, 32'd1);                  // books at the bottom
    add_req(32'd0, 32'd1);                  // exact repeat overlaps
    add_req(32'd1, 32'd2);                  // touches previous end
    add_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);  // top of range
    add_req(32'd0, 32'hFFFF_FFFF);          // covers everything
    add_req(32'd100, 32'd200);
    add_req(32'd50, 32'd100);               // ends where one starts
    add_req(32'd200, 32'd300);              // starts where one ends
    add_req(32'd150, 32'd160);              // inside a stored one
    add_req(32'd90, 32'd110);               // straddles a start
    add_req(32'd190, 32'd210);              // straddles a join
    add_req(32'd10, 32'd1000);              // covers several
    add_req(32'hFFFF_FFFD, 32'hFFFF_FFFE);  // touches the top one
    add_req(32'd1000, 32'h8000_0000);
    add_req(32'h8000_0000, 32'hFFFF_FFFD);  // fills the gap below the top

    // random: mostly shapes that can fit or just miss, so the table fills,
    // then full and overlap-while-full keep getting hit
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        s = $urandom();
        e = $urandom();
      end else if (r < 18) begin
        s = $urandom();
        e = $urandom_range(0, s);
      end else if (r < 42) begin
        k   = $urandom_range(0, hist_start.size() - 1);
        len = $urandom_range(1, 32'h0010_0000);
        if ($urandom_range(0, 1) == 0) begin
          s = hist_end[k];
          e = s + len;
        end else begin
          e = hist_start[k];
          s = (e > len) ? e - len : 32'd0;
        end
      end else begin
        bucket = $urandom_range(0, 255);
        s      = {bucket, 24'($urandom())};
        e      = s + $urandom_range(1, 32'h0040_0000);
      end
      add_req(s, e);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (booking_results.size() != 0) @(posedge clk_i);
    // a full scan plus margin, so a stray extra result still shows up
    repeat (100) @(posedge clk_i);

    if (n_errors == 0 && booking_results.size() == 0) begin
      $display("[interval_booking_table] OK");
    end else begin
      $display("[interval_booking_table] ERROR");
    end
    $finish;
  end

  // hard limit: well beyond the slowest legal run (full-table scans on every
  // request, worst idling on both sides, the long hold-off)
  initial begin
    #12_000_000;
    $display("[interval_booking_table] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ibt_pkg.sv
hdl/ibt_entry_ram.sv
hdl/ibt_scan_ctrl.sv
hdl/interval_booking_table.sv
tb/tb_interval_booking_table.sv
